// File: sv/rfa_pkg.sv
// Shared types and constants for the rational fraction ALU.
package rfa_pkg;

  localparam int VW = 32;
  localparam int MW = 2 * VW;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_LT  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               is_less;
    logic [1:0]         status;
  } out_item_t;

  // Classified operation handed from the front end to the back end.
  // OP_REDUCE: product form (mul/div), OP_SUM: cross-product sum (add/sub).
  typedef enum logic [1:0] {
    OP_DONE   = 2'd0,
    OP_LT     = 2'd1,
    OP_REDUCE = 2'd2,
    OP_SUM    = 2'd3
  } op_t;

  typedef struct packed {
    op_t            op;
    logic [1:0]     status;
    logic           neg;
    logic [VW-1:0]  p_mag;
    logic [VW-1:0]  q_mag;
    logic [VW-1:0]  r_mag;
    logic [VW-1:0]  s_mag;
    logic           r_neg;
    logic           sub;
  } task_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MUL1,
    BK_MUL2,
    BK_COMB,
    BK_GCD,
    BK_GWAIT,
    BK_DIVN,
    BK_DIVD,
    BK_OUT
  } bk_state_t;

endpackage

// File: sv/rfa_front.sv
// Front end: sign normalization and command classification.
module rfa_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rfa_pkg::in_item_t in_item,
  output logic             q_valid,
  input  logic             q_ready,
  output rfa_pkg::task_t   q_task
);

  localparam int VW = rfa_pkg::VW;

  logic [VW:0]   an_m, ad_m, bn_m, bd_m;
  logic          an_s, ad_s, bn_s, bd_s;
  logic [VW-1:0] an_v, ad_v, bn_v, bd_v;
  logic          ann, bnn;
  rfa_pkg::task_t t;

  // Magnitude of a sign-extended value; -2^(VW-1) needs VW bits, kept in VW+1.
  function automatic logic [VW:0] mag_of(input logic [VW-1:0] v);
    logic [VW:0] x;
    x = {1'b0, v};
    return v[VW-1] ? ({1'b1, {VW{1'b0}}} - x) : x;
  endfunction

  assign an_v = in_item.a_num[VW-1:0];
  assign ad_v = in_item.a_den[VW-1:0];
  assign bn_v = in_item.b_num[VW-1:0];
  assign bd_v = in_item.b_den[VW-1:0];
  assign an_s = an_v[VW-1];
  assign ad_s = ad_v[VW-1];
  assign bn_s = bn_v[VW-1];
  assign bd_s = bd_v[VW-1];
  assign an_m = mag_of(an_v);
  assign ad_m = mag_of(ad_v);
  assign bn_m = mag_of(bn_v);
  assign bd_m = mag_of(bd_v);
  assign ann  = (an_s != ad_s) && (an_m != '0);
  assign bnn  = (bn_s != bd_s) && (bn_m != '0);

  // Magnitudes up to 2^(VW-1) fit VW bits.
  always_comb begin
    t        = '0;
    t.op     = rfa_pkg::OP_DONE;
    t.status = rfa_pkg::ST_OK;
    if (in_item.command > 3'(rfa_pkg::CMD_LT)) begin
      t.op = rfa_pkg::OP_DONE;
    end else if (ad_m == '0 || bd_m == '0) begin
      t.status = rfa_pkg::ST_ZERO_DEN;
    end else begin
      case (rfa_pkg::cmd_t'(in_item.command))
        rfa_pkg::CMD_LT: begin
          t.op = rfa_pkg::OP_LT;
          t.neg = ann; t.p_mag = an_m[VW-1:0]; t.q_mag = bd_m[VW-1:0];
          t.r_neg = bnn; t.r_mag = bn_m[VW-1:0]; t.s_mag = ad_m[VW-1:0];
        end
        rfa_pkg::CMD_ADD, rfa_pkg::CMD_SUB: begin
          t.op = rfa_pkg::OP_SUM;
          t.neg = ann; t.p_mag = an_m[VW-1:0]; t.q_mag = bd_m[VW-1:0];
          t.r_neg = bnn; t.r_mag = bn_m[VW-1:0]; t.s_mag = ad_m[VW-1:0];
          t.sub = (in_item.command == 3'(rfa_pkg::CMD_SUB));
        end
        rfa_pkg::CMD_MUL: begin
          t.op = rfa_pkg::OP_REDUCE;
          t.neg = ann != bnn; t.p_mag = an_m[VW-1:0]; t.q_mag = bn_m[VW-1:0];
          t.r_mag = ad_m[VW-1:0]; t.s_mag = bd_m[VW-1:0];
        end
        rfa_pkg::CMD_DIV: begin
          if (bn_m == '0) begin
            t.status = rfa_pkg::ST_ZERO_DEN;
          end else begin
            t.op = rfa_pkg::OP_REDUCE;
            t.neg = ann != bnn; t.p_mag = an_m[VW-1:0]; t.q_mag = bd_m[VW-1:0];
            t.r_mag = ad_m[VW-1:0]; t.s_mag = bn_m[VW-1:0];
          end
        end
        default: t.op = rfa_pkg::OP_DONE;
      endcase
    end
  end

  // Two-entry queue to the back end.
  rfa_pkg::task_t q_mem [2];
  logic           wr_ptr, rd_ptr;
  logic [1:0]     count;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_task   = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_mem[wr_ptr] <= t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (in_valid && in_ready) wr_ptr <= ~wr_ptr;
      if (q_valid && q_ready) rd_ptr <= ~rd_ptr;
      count <= count + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
    end
  end

`ifndef SYNTH
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !in_ready) else $error("queue overfill");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count corrupt");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_ready && q_valid |-> count != 2'd0) else $error("pop from empty");
`endif

endmodule

// File: sv/rfa_divider.sv
// Restoring radix-2 divider for 2*VW-bit unsigned values, one bit per cycle.
module rfa_divider (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [rfa_pkg::MW-1:0]   dividend,
  input  logic [rfa_pkg::MW-1:0]   divisor,
  output logic                     done,
  output logic [rfa_pkg::MW-1:0]   quotient,
  output logic [rfa_pkg::MW-1:0]   remainder
);

  localparam int MW = rfa_pkg::MW;
  localparam int CW = $clog2(MW + 1);

  logic [MW-1:0] quo, rem, dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [MW:0]   trial;

  assign trial     = {rem, quo[MW-1]} - {1'b0, dvs};
  assign quotient  = quo;
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(MW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[MW]) begin
        rem <= trial[MW-1:0];
        quo <= {quo[MW-2:0], 1'b1};
      end else begin
        rem <= {rem[MW-2:0], quo[MW-1]};
        quo <= {quo[MW-2:0], 1'b0};
      end
    end
  end

`ifndef SYNTH
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy && cnt != CW'(1) |=> busy) else $error("divider dropped busy");
  a_done_after: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("done without work");
`endif

endmodule

// File: sv/rfa_back.sv
// Back end: cross products, Euclid reduction, range check, output register.
module rfa_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_ready,
  input  rfa_pkg::task_t     q_task,
  output logic               out_valid,
  input  logic               out_ready,
  output rfa_pkg::out_item_t out_item
);

  localparam int VW = rfa_pkg::VW;
  localparam int MW = rfa_pkg::MW;
  localparam logic [MW-1:0] LIMIT = MW'((64'd1 << (VW - 1)) - 64'd1);

  rfa_pkg::bk_state_t state, state_next;
  rfa_pkg::task_t     tk;
  logic [MW-1:0]      m1, m2, x, y, num_mag, den;
  logic               neg;
  logic               div_start, div_done;
  logic [MW-1:0]      div_a, div_b, div_q, div_r;
  logic [VW-1:0]      ma, mb;
  logic [MW-1:0]      prod;
  rfa_pkg::out_item_t res;
  logic               t2n, addsub, out_load;
  logic [MW:0]        sum;
  logic [MW-1:0]      num_c, den_c;
  logic               neg_c;

  // One shared VW x VW multiplier, registered after use.
  always_comb begin
    ma = tk.p_mag;
    mb = tk.q_mag;
    case (state)
      rfa_pkg::BK_MUL2: begin
        ma = tk.r_mag;
        mb = tk.s_mag;
      end
      rfa_pkg::BK_COMB: begin
        ma = tk.s_mag;
        mb = tk.q_mag;
      end
      default: ;
    endcase
  end
  assign prod = MW'(ma) * MW'(mb);

  rfa_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(div_q), .remainder(div_r)
  );

  // Signed combine of the two cross products for add/sub.
  assign addsub = (tk.op == rfa_pkg::OP_SUM);
  assign t2n    = (tk.r_neg ^ tk.sub) && (m2 != '0);
  assign sum    = (tk.neg == t2n) ? ({1'b0, m1} + {1'b0, m2}) :
                  (m1 >= m2) ? {1'b0, m1 - m2} : {1'b0, m2 - m1};
  assign num_c  = addsub ? sum[MW-1:0] : m1;
  assign den_c  = addsub ? prod : m2;
  assign neg_c  = addsub ? (((tk.neg == t2n) || (m1 >= m2)) ? tk.neg : t2n) : tk.neg;

  // Result register may load when empty or being drained this cycle.
  assign out_load = (state == rfa_pkg::BK_OUT) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    div_start  = 1'b0;
    div_a      = x;
    div_b      = y;
    case (state)
      rfa_pkg::BK_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          state_next = (q_task.op == rfa_pkg::OP_DONE) ? rfa_pkg::BK_OUT
                                                        : rfa_pkg::BK_MUL1;
        end
      end
      rfa_pkg::BK_MUL1: state_next = rfa_pkg::BK_MUL2;
      rfa_pkg::BK_MUL2: state_next = rfa_pkg::BK_COMB;
      rfa_pkg::BK_COMB: begin
        if (tk.op == rfa_pkg::OP_LT || num_c == '0) state_next = rfa_pkg::BK_OUT;
        else state_next = rfa_pkg::BK_GCD;
      end
      rfa_pkg::BK_GCD: begin
        div_start = 1'b1;
        if (y == '0) begin
          // x holds the GCD: divide it out of the numerator first
          div_a = num_mag;
          div_b = x;
          state_next = rfa_pkg::BK_DIVN;
        end else begin
          state_next = rfa_pkg::BK_GWAIT;
        end
      end
      rfa_pkg::BK_GWAIT: if (div_done) state_next = rfa_pkg::BK_GCD;
      rfa_pkg::BK_DIVN: if (div_done) begin
        div_start = 1'b1;
        div_a = den;
        div_b = x;
        state_next = rfa_pkg::BK_DIVD;
      end
      rfa_pkg::BK_DIVD: if (div_done) state_next = rfa_pkg::BK_OUT;
      rfa_pkg::BK_OUT: if (out_load) state_next = rfa_pkg::BK_IDLE;
      default: state_next = rfa_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rfa_pkg::BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      rfa_pkg::BK_IDLE: if (q_valid) tk <= q_task;
      rfa_pkg::BK_MUL1: m1 <= prod;
      rfa_pkg::BK_MUL2: m2 <= prod;
      rfa_pkg::BK_COMB: begin
        num_mag <= num_c;
        den     <= den_c;
        neg     <= neg_c;
        x       <= num_c;
        y       <= den_c;
      end
      rfa_pkg::BK_GWAIT: if (div_done) begin
        x <= y;
        y <= div_r;
      end
      rfa_pkg::BK_DIVN: if (div_done) num_mag <= div_q;
      rfa_pkg::BK_DIVD: if (div_done) den <= div_q;
      rfa_pkg::BK_OUT: if (out_load) out_item <= res;
      default: ;
    endcase
  end

  always_comb begin
    res = '0;
    case (tk.op)
      rfa_pkg::OP_DONE: res.status = tk.status;
      rfa_pkg::OP_LT: begin
        if (tk.neg != t2n) res.is_less = tk.neg;
        else if (tk.neg) res.is_less = (m1 > m2);
        else res.is_less = (m1 < m2);
      end
      default: begin
        if (num_mag == '0) begin
          res.res_den = 31'd1;
        end else if (den > LIMIT || num_mag > (LIMIT + MW'(neg))) begin
          res.status = rfa_pkg::ST_OVERFLOW;
        end else begin
          res.res_num = 32'(neg ? (MW'(0) - num_mag) : num_mag);
          res.res_den = 31'(den);
        end
      end
    endcase
  end

`ifndef SYNTH
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_item)) else $error("result changed");
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    q_ready |-> state == rfa_pkg::BK_IDLE) else $error("bad take");
  a_out_from_state: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == rfa_pkg::BK_OUT) else $error("stray out");
`endif

endmodule

// File: sv/rational_fraction_alu.sv
// Rational fraction ALU: a front end normalizes signs and classifies each beat
// into a two-entry queue; the back end forms cross products on one shared
// 32x32 multiplier, reduces by Euclid's algorithm on a 64-bit radix-2 divider
// and divides numerator and denominator by the GCD with two more divider
// passes. Errors and unknown commands go straight to the output register and
// compares stop after the cross products. One item is in the back end at a
// time, and a finished beat waits in the output register while the next one
// is worked. Results: status 1 on zero denominator, 2 on overflow.
module rational_fraction_alu (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rfa_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output rfa_pkg::out_item_t out_item
);

  logic           q_valid, q_ready;
  rfa_pkg::task_t q_task;

  rfa_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_task(q_task)
  );

  rfa_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_task(q_task),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

endmodule
